// ----- hw/rtl/skq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted key queue package
// Operation and status codes, field widths and default sizes shared by the
// channel interfaces and the sorted key queue.
// ----------------------------------------------------------------------------
package skq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int INDEX_W       = 16;
  localparam int VALUE_W       = 32;
  localparam int OCC_W         = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_RANGE  = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

// ----- hw/rtl/skq_if.sv -----
// ----------------------------------------------------------------------------
// Sorted key queue channels
// Request and response channels with a valid and ready handshake; an item
// moves at a rising edge with both valid and ready high.
// ----------------------------------------------------------------------------
interface skq_req_if;
  import skq_pkg::*;

  logic                       valid;
  logic                       ready;
  op_t                        operation;
  logic [INDEX_W-1:0]         entry_index;
  logic signed [VALUE_W-1:0]  entry_value;
  logic signed [VALUE_W-1:0]  range_low;
  logic signed [VALUE_W-1:0]  range_high;

  modport source (
    output valid, operation, entry_index, entry_value, range_low, range_high,
    input  ready
  );

  modport sink (
    input  valid, operation, entry_index, entry_value, range_low, range_high,
    output ready
  );
endinterface

interface skq_rsp_if;
  import skq_pkg::*;

  logic                       valid;
  logic                       ready;
  status_t                    status;
  logic [INDEX_W-1:0]         out_index;
  logic signed [VALUE_W-1:0]  out_value;
  logic                       last;
  logic [OCC_W-1:0]           occupancy;

  modport source (
    output valid, status, out_index, out_value, last, occupancy,
    input  ready
  );

  modport sink (
    input  valid, status, out_index, out_value, last, occupancy,
    output ready
  );
endinterface

// ----- hw/rtl/sorted_key_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Sorted key queue unit
// Holds up to DEPTH (index, value) entries in ascending signed value order in
// a single-port-read, single-port-write memory, with arrival order kept among
// equal values, and serves insert, pop, range delete and delete by index.
// ----------------------------------------------------------------------------
// The queue takes one request item at a time and drops ready until that item
// is fully done; a finished response item waits in an output register, so a
// new request is taken while it is still pending. Every operation walks the
// entry memory one entry per clock, unless the response side stalls, through
// its one read and one write port: an insert scans to its place and then
// shifts the tail up; pop, range delete and delete by index scan to the
// entries they remove and then shift the rest down. A range delete sends one
// response item per removed entry, the final one marked last. A stalled
// response side holds the unit where it is. There is no clearing pass after
// reset.
module sorted_key_queue_unit #(
  parameter int DEPTH = skq_pkg::DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  skq_req_if.sink  req,
  skq_rsp_if.source rsp
);
  import skq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_INS_SCAN  = 7'b0000010,
    S_INS_SHIFT = 7'b0000100,
    S_HEAD_SCAN = 7'b0001000,
    S_DEL_SCAN  = 7'b0010000,
    S_COMPACT   = 7'b0100000,
    S_RESP      = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] rm_n, rm_n_next;
  logic          have_pend, have_pend_next;
  logic [INDEX_W-1:0]        pend_idx, pend_idx_next;
  logic signed [VALUE_W-1:0] pend_val, pend_val_next;
  status_t       resp_status, resp_status_next;

  op_t                       op_q;
  logic [INDEX_W-1:0]        idx_q;
  logic signed [VALUE_W-1:0] val_q;
  logic signed [VALUE_W-1:0] lo_q;
  logic signed [VALUE_W-1:0] hi_q;

  logic signed [VALUE_W-1:0] key_mem [DEPTH];
  logic [INDEX_W-1:0]        idx_mem [DEPTH];
  logic signed [VALUE_W-1:0] rd_key;
  logic [INDEX_W-1:0]        rd_idx;
  logic [CW-1:0]             rd_ptr;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic                      we;
  logic signed [VALUE_W-1:0] wr_key;
  logic [INDEX_W-1:0]        wr_idx;

  logic                      out_valid;
  logic                      out_free;
  logic                      out_load;
  status_t                   ld_status;
  logic [INDEX_W-1:0]        ld_index;
  logic signed [VALUE_W-1:0] ld_value;
  logic                      ld_last;
  logic [OCC_W-1:0]          ld_occ;
  status_t                   out_status;
  logic [INDEX_W-1:0]        out_index_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                      out_last;
  logic [OCC_W-1:0]          out_occ;

  logic take;

  assign req.ready     = (state == S_IDLE);
  assign out_free      = !out_valid || rsp.ready;
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.out_index = out_index_q;
  assign rsp.out_value = out_value_q;
  assign rsp.last      = out_last;
  assign rsp.occupancy = out_occ;

  assign rd_addr = rd_ptr[AW-1:0];
  assign wr_addr = ptr[AW-1:0];

  always_comb begin
    if (op_q == OP_POP) begin
      take = (ptr != count) && (ptr == '0);
    end else begin
      take = (ptr != count) && (rd_key >= lo_q) && (rd_key < hi_q);
    end
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    ptr_next         = ptr;
    pos_next         = pos;
    rm_n_next        = rm_n;
    have_pend_next   = have_pend;
    pend_idx_next    = pend_idx;
    pend_val_next    = pend_val;
    resp_status_next = resp_status;
    rd_ptr           = ptr;
    we               = 1'b0;
    wr_key           = rd_key;
    wr_idx           = rd_idx;
    out_load         = 1'b0;
    ld_status        = ST_OK;
    ld_index         = '0;
    ld_value         = '0;
    ld_last          = 1'b1;
    ld_occ           = OCC_W'(count);

    unique case (state)
      S_IDLE: begin
        rd_ptr = '0;
        if (req.valid) begin
          ptr_next       = '0;
          have_pend_next = 1'b0;
          unique case (req.operation)
            OP_INSERT: begin
              if (count == CW'(DEPTH)) begin
                resp_status_next = ST_FULL;
                state_next       = S_RESP;
              end else begin
                state_next = S_INS_SCAN;
              end
            end
            OP_POP, OP_RANGE: state_next = S_HEAD_SCAN;
            OP_DELETE:        state_next = S_DEL_SCAN;
            default:          state_next = S_IDLE;
          endcase
        end
      end

      S_INS_SCAN: begin
        if (ptr != count && rd_key <= val_q) begin
          ptr_next = CW'(ptr + 1'b1);
          rd_ptr   = CW'(ptr + 1'b1);
        end else begin
          pos_next   = ptr;
          ptr_next   = count;
          rd_ptr     = CW'(count - 1'b1);
          state_next = S_INS_SHIFT;
        end
      end

      S_INS_SHIFT: begin
        we = 1'b1;
        if (ptr == pos) begin
          wr_key           = val_q;
          wr_idx           = idx_q;
          count_next       = CW'(count + 1'b1);
          resp_status_next = ST_OK;
          state_next       = S_RESP;
        end else begin
          ptr_next = CW'(ptr - 1'b1);
          rd_ptr   = CW'(ptr - 2'd2);
        end
      end

      S_HEAD_SCAN: begin
        if (have_pend && !out_free) begin
          state_next = S_HEAD_SCAN;
        end else if (take) begin
          if (have_pend) begin
            out_load = 1'b1;
            ld_index = pend_idx;
            ld_value = pend_val;
            ld_last  = 1'b0;
            ld_occ   = OCC_W'(count - ptr);
          end
          pend_idx_next  = rd_idx;
          pend_val_next  = rd_key;
          have_pend_next = 1'b1;
          ptr_next       = CW'(ptr + 1'b1);
          rd_ptr         = CW'(ptr + 1'b1);
        end else if (have_pend) begin
          out_load       = 1'b1;
          ld_index       = pend_idx;
          ld_value       = pend_val;
          ld_occ         = OCC_W'(count - ptr);
          have_pend_next = 1'b0;
          rm_n_next      = ptr;
          ptr_next       = '0;
          state_next     = S_COMPACT;
        end else begin
          resp_status_next = ST_EMPTY;
          state_next       = S_RESP;
        end
      end

      S_DEL_SCAN: begin
        if (ptr == count) begin
          resp_status_next = ST_NOT_FOUND;
          state_next       = S_RESP;
        end else if (rd_idx == idx_q) begin
          if (out_free) begin
            out_load   = 1'b1;
            ld_index   = rd_idx;
            ld_value   = rd_key;
            ld_occ     = OCC_W'(count - 1'b1);
            rm_n_next  = CW'(1);
            rd_ptr     = CW'(ptr + 1'b1);
            state_next = S_COMPACT;
          end
        end else begin
          ptr_next = CW'(ptr + 1'b1);
          rd_ptr   = CW'(ptr + 1'b1);
        end
      end

      S_COMPACT: begin
        if (({1'b0, ptr} + {1'b0, rm_n}) >= {1'b0, count}) begin
          count_next = count - rm_n;
          state_next = S_IDLE;
        end else begin
          we       = 1'b1;
          ptr_next = CW'(ptr + 1'b1);
          rd_ptr   = CW'(ptr + rm_n + 1'b1);
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_status  = resp_status;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      have_pend <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      have_pend <= have_pend_next;
    end
    ptr         <= ptr_next;
    pos         <= pos_next;
    rm_n        <= rm_n_next;
    pend_idx    <= pend_idx_next;
    pend_val    <= pend_val_next;
    resp_status <= resp_status_next;
    if (state == S_IDLE && req.valid) begin
      op_q  <= req.operation;
      idx_q <= req.entry_index;
      val_q <= req.entry_value;
      lo_q  <= req.range_low;
      hi_q  <= req.range_high;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wr_addr] <= wr_key;
      idx_mem[wr_addr] <= wr_idx;
    end
    rd_key <= key_mem[rd_addr];
    rd_idx <= idx_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_status  <= ld_status;
      out_index_q <= ld_index;
      out_value_q <= ld_value;
      out_last    <= ld_last;
      out_occ     <= ld_occ;
    end
  end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Sorted key queue unit testbench
// Drives insert, pop, range delete and delete by index items into the queue.
// Every accepted item is run through a sorted entry model that predicts each
// response item, and each response is checked field by field in order. Both
// channels idle and stall at random. A watchdog ends the run if traffic stops.
// ----------------------------------------------------------------------------
module tb;
  import skq_pkg::*;

  localparam int DEPTH          = DEPTH_DEFAULT;
  localparam int RANGE_RUN_MAX  = 64;
  localparam int RANDOM_ITEMS   = 290;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct {
    op_t                       operation;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] low;
    logic signed [VALUE_W-1:0] high;
  } req_item_t;

  typedef struct {
    status_t                   status;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic [OCC_W-1:0]          occupancy;
  } rsp_item_t;

  typedef struct {
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
  } held_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  skq_req_if req_ch ();
  skq_rsp_if rsp_ch ();

  sorted_key_queue_unit #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #1 clk = ~clk;

  req_item_t   req_backlog[$];
  rsp_item_t   due_results[$];
  held_entry_t held[$];
  req_item_t   cur_req;
  int unsigned req_gap;
  int unsigned rsp_stall;
  bit          req_steady;
  bit          rsp_steady;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned random_count;

  function automatic int unsigned idle_gap(inout bit steady);
    int unsigned pick;
    if ($urandom_range(0, 49) == 0) steady = !steady;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void due_result(status_t status, logic [INDEX_W-1:0] index,
                                     logic signed [VALUE_W-1:0] value, logic last);
    rsp_item_t r;
    r.status    = status;
    r.index     = index;
    r.value     = value;
    r.last      = last;
    r.occupancy = OCC_W'(held.size());
    due_results.insert(due_results.size(), r);
  endfunction

  function automatic void advance_sorted_model(req_item_t r);
    held_entry_t e;
    int pos;
    int run;
    case (r.operation)
      OP_INSERT: begin
        if (held.size() >= DEPTH) begin
          due_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < held.size() && held[pos].value <= r.value) pos++;
          e.index = r.index;
          e.value = r.value;
          held.insert(pos, e);
          due_result(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_POP: begin
        if (held.size() == 0) begin
          due_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          e = held.pop_front();
          due_result(ST_OK, e.index, e.value, 1'b1);
        end
      end
      OP_RANGE: begin
        run = 0;
        while (run < held.size() && run < RANGE_RUN_MAX &&
               held[run].value >= r.low && held[run].value < r.high) run++;
        if (run == 0) begin
          due_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int k = 0; k < run; k++) begin
            e = held.pop_front();
            due_result(ST_OK, e.index, e.value, k == run - 1);
          end
        end
      end
      default: begin
        pos = -1;
        for (int k = 0; k < held.size(); k++) begin
          if (pos < 0 && held[k].index == r.index) pos = k;
        end
        if (pos < 0) begin
          due_result(ST_NOT_FOUND, '0, '0, 1'b1);
        end else begin
          e = held[pos];
          held.delete(pos);
          due_result(ST_OK, e.index, e.value, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] pool_value();
    int v;
    v = $urandom_range(0, 15);
    v = (v - 8) * 65536;
    if ($urandom_range(0, 1) != 0) v += 32768;
    return v;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return pool_value();
    if (sel == 5) begin
      case ($urandom_range(0, 3))
        0: return VALUE_MIN;
        1: return VALUE_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return INDEX_W'($urandom_range(0, 15));
    if (sel == 6) return '1;
    return INDEX_W'($urandom_range(0, 65535));
  endfunction

  // Range bounds and delete indexes are mostly taken from the entries held at
  // the start of the batch, so that most range deletes and deletes by index
  // really remove entries.
  function automatic req_item_t random_request(op_t op);
    req_item_t r;
    int unsigned sel;
    r.operation = op;
    r.index     = pick_index();
    r.value     = pick_value();
    r.low       = $urandom;
    r.high      = $urandom;
    if ($urandom_range(0, 9) == 0) return r;
    if (op == OP_RANGE && held.size() > 0) begin
      sel = $urandom_range(0, 4);
      if (sel == 0) begin
        r.low  = VALUE_MIN;
        r.high = VALUE_MAX;
      end else if (sel < 4) begin
        r.low = held[0].value - $urandom_range(0, 2);
        if (r.low > held[0].value) r.low = held[0].value;
        r.high = held[$urandom_range(0, held.size() - 1)].value + $urandom_range(0, 1);
      end
    end
    if (op == OP_DELETE && held.size() > 0 && $urandom_range(0, 3) != 0) begin
      r.index = held[$urandom_range(0, held.size() - 1)].index;
    end
    return r;
  endfunction

  function automatic void post_request(op_t op, logic [INDEX_W-1:0] index,
                                       logic signed [VALUE_W-1:0] value,
                                       logic signed [VALUE_W-1:0] low,
                                       logic signed [VALUE_W-1:0] high);
    req_item_t r;
    r.operation = op;
    r.index     = index;
    r.value     = value;
    r.low       = low;
    r.high      = high;
    req_backlog.insert(req_backlog.size(), r);
  endfunction

  function automatic void post_random(op_t op);
    req_backlog.insert(req_backlog.size(), random_request(op));
    random_count++;
  endfunction

  task automatic wait_drained();
    while (req_backlog.size() != 0 || req_ch.valid || due_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) advance_sorted_model(cur_req);
      if (!req_ch.valid || req_ch.ready) begin
        if (req_gap != 0) begin
          req_gap--;
          req_ch.valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          cur_req = req_backlog.pop_front();
          req_ch.operation   <= cur_req.operation;
          req_ch.entry_index <= cur_req.index;
          req_ch.entry_value <= cur_req.value;
          req_ch.range_low   <= cur_req.low;
          req_ch.range_high  <= cur_req.high;
          req_ch.valid       <= 1'b1;
          req_gap = idle_gap(req_steady);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected result: status %0d index %h value %h last %b occupancy %0d",
                     rsp_ch.status, rsp_ch.out_index, rsp_ch.out_value, rsp_ch.last,
                     rsp_ch.occupancy);
          end
        end else begin
          want = due_results.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.out_index !== want.index ||
              rsp_ch.out_value !== want.value || rsp_ch.last !== want.last ||
              rsp_ch.occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch: expected status %0d index %h value %h last %b occupancy %0d",
                       want.status, want.index, want.value, want.last, want.occupancy);
              $display("          got      status %0d index %h value %h last %b occupancy %0d",
                       rsp_ch.status, rsp_ch.out_index, rsp_ch.out_value, rsp_ch.last,
                       rsp_ch.occupancy);
            end
          end
        end
      end
      if (rsp_stall != 0) begin
        rsp_stall--;
        rsp_ch.ready <= 1'b0;
      end else if (!rsp_ch.ready) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_stall = idle_gap(rsp_steady);
        rsp_ch.ready <= (rsp_stall == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned kind;
    int unsigned count;
    int unsigned pick;
    req_ch.valid       = 1'b0;
    req_ch.operation   = OP_INSERT;
    req_ch.entry_index = '0;
    req_ch.entry_value = '0;
    req_ch.range_low   = '0;
    req_ch.range_high  = '0;
    rsp_ch.ready       = 1'b0;
    req_gap      = 0;
    rsp_stall    = 0;
    req_steady   = 1'b0;
    rsp_steady   = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    random_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty queue cases, extremes of the value range, equal values in
    // arrival order, duplicate indexes and range deletes that remove nothing.
    post_request(OP_POP,    '0, '0, '0, '0);
    post_request(OP_RANGE,  '0, '0, VALUE_MIN, VALUE_MAX);
    post_request(OP_DELETE, '0, '0, '0, '0);
    post_request(OP_INSERT, '1, VALUE_MAX, '0, '0);
    post_request(OP_INSERT, '0, VALUE_MIN, '0, '0);
    post_request(OP_INSERT, 16'd5, '0, '0, '0);
    post_request(OP_INSERT, 16'd6, '0, '0, '0);
    post_request(OP_INSERT, 16'd5, '0, '0, '0);
    post_request(OP_INSERT, 16'd7, '1, '0, '0);
    post_request(OP_INSERT, 16'd8, 32'sh0001_0000, '0, '0);
    post_request(OP_RANGE,  '0, '0, '0, '0);
    post_request(OP_RANGE,  '0, '0, 32'sh0000_0005, 32'sh0000_0001);
    post_request(OP_RANGE,  '0, '0, '0, VALUE_MAX);
    post_request(OP_POP,    '0, '0, '0, '0);
    post_request(OP_DELETE, 16'd5, '0, '0, '0);
    post_request(OP_RANGE,  '0, '0, VALUE_MIN, 32'sh0001_0000);
    post_request(OP_DELETE, '1, '0, '0, '0);
    post_request(OP_DELETE, 16'd9, '0, '0, '0);
    post_request(OP_POP,    '0, '0, '0, '0);
    post_request(OP_POP,    '0, '0, '0, '0);
    wait_drained();

    // Fill to the brim and past it, then empty the whole queue in one range
    // delete.
    while (held.size() + req_backlog.size() < DEPTH + 2) begin
      post_request(OP_INSERT, pick_index(), pool_value(), $urandom, $urandom);
      random_count++;
    end
    wait_drained();
    post_request(OP_RANGE, INDEX_W'($urandom), $urandom, VALUE_MIN, VALUE_MAX);
    random_count++;
    wait_drained();

    while (random_count < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        for (int k = 0; k < 12; k++) begin
          pick = $urandom_range(0, 19);
          if (pick < 9) post_random(OP_INSERT);
          else if (pick < 12) post_random(OP_POP);
          else if (pick < 16) post_random(OP_RANGE);
          else post_random(OP_DELETE);
        end
      end else if (kind < 7) begin
        for (int k = 0; k < 14; k++) post_random(OP_INSERT);
        post_random(OP_POP);
      end else if (kind < 9) begin
        for (int k = 0; k < 6; k++) post_random(OP_RANGE);
      end else begin
        count = DEPTH - held.size() + 2;
        for (int k = 0; k < count; k++) post_random(OP_INSERT);
      end
      wait_drained();
    end

    repeat (2 * DEPTH + 8) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/skq_pkg.sv
hw/rtl/skq_if.sv
hw/rtl/sorted_key_queue_unit.sv
verif/tb.sv
